/* rtl/sphere_sphere_contact_core_macros.svh */
// Assertion helpers; clk and rst_n are taken from the including scope.
`ifndef SPHERE_SPHERE_CONTACT_CORE_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_CORE_MACROS_SVH

// Same-cycle implication.
`define SSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("sphere contact core check failed");

// Implication checked on the following clock.
`define SSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sphere contact core check failed");

`endif

/* rtl/ssc_pkg.sv */
package ssc_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int SEP_W   = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 65;
  localparam int DD_W    = 67;
  localparam int RR_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 34;
  localparam int QUO_W   = 31;
  localparam int NUM_W   = MAG_W + 30 + 1;
  localparam int NORM_W  = 32;

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  // s1..s5, root steps, divider setup, quotient steps, output register
  localparam int LATENCY    = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [NORM_W-1:0] NORMAL_ONE = 32'h4000_0000;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_OWN_RADIUS = 3'd3,
    REG_MIN_SEP    = 3'd4
  } reg_idx_t;

  // sideband that rides along the root and divider pipelines
  typedef struct packed {
    logic                  touch;
    logic                  norm_en;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

endpackage

/* rtl/sphere_sphere_contact_core.sv */
// Sphere-sphere contact test against a fixed sphere held in registers.
// Config: cfg_valid/cfg_ready write channel; cfg_index selects center_x,
// center_y, center_z, own_radius, min_separation (0..4), cfg_data is the
// word. Other indexes are dropped. cfg_ready is always high. Write only
// while no items are in flight.
// Input: a probe sphere word is taken on each clock with start high and
// busy low. busy is always low, so a new probe may enter every cycle.
// Output: out_valid strobes for one cycle with the result word; there is
// no backpressure, the receiver must take it.
// One item per cycle sustained. The depth is set by the 32 one-bit steps
// of the square root and the 31 one-bit steps of the shared-divisor
// normal divider.
// Reset (rst_n low, synchronous) clears every valid bit and loads the
// register reset values: center and radius zero, min_separation one.
module sphere_sphere_contact_core
  import ssc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  in_probe_x,
  input  logic signed [COORD_W-1:0]  in_probe_y,
  input  logic signed [COORD_W-1:0]  in_probe_z,
  input  logic [RAD_W-1:0]           in_probe_radius,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                cfg_data,
  output logic                       out_valid,
  output logic                       out_touching,
  output logic signed [COORD_W-1:0]  out_contact_x,
  output logic signed [COORD_W-1:0]  out_contact_y,
  output logic signed [COORD_W-1:0]  out_contact_z,
  output logic signed [NORM_W-1:0]   out_normal_x,
  output logic signed [NORM_W-1:0]   out_normal_y,
  output logic signed [NORM_W-1:0]   out_normal_z
);

`include "sphere_sphere_contact_core_macros.svh"

  // ---------------- configuration
  logic signed [COORD_W-1:0] ctr_x_r, ctr_y_r, ctr_z_r;
  logic [RAD_W-1:0]          own_rad_r;
  logic [SEP_W-1:0]          min_sep_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r   <= '0;
      ctr_y_r   <= '0;
      ctr_z_r   <= '0;
      own_rad_r <= '0;
      min_sep_r <= SEP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:   ctr_x_r   <= cfg_data;
        REG_CENTER_Y:   ctr_y_r   <= cfg_data;
        REG_CENTER_Z:   ctr_z_r   <= cfg_data;
        REG_OWN_RADIUS: own_rad_r <= cfg_data[RAD_W-1:0];
        REG_MIN_SEP:    min_sep_r <= cfg_data[SEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*SEP_W-1:0] sep_sq;
  assign sep_sq = min_sep_r * min_sep_r;

  // ---------------- s1: offsets and radius sum
  logic                     s1_vld_r;
  logic signed [DIFF_W-1:0] s1_d_r [3];
  logic [RAD_W:0]           s1_rsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_d_r[0] <= DIFF_W'(in_probe_x) - DIFF_W'(ctr_x_r);
    s1_d_r[1] <= DIFF_W'(in_probe_y) - DIFF_W'(ctr_y_r);
    s1_d_r[2] <= DIFF_W'(in_probe_z) - DIFF_W'(ctr_z_r);
    s1_rsum_r <= {1'b0, own_rad_r} + {1'b0, in_probe_radius};
  end

  // ---------------- s2: magnitudes, radius square
  logic              s2_vld_r;
  logic [DIFF_W-1:0] s2_mag_r [3];
  logic [2:0]        s2_neg_r;
  logic [RR_W-1:0]   s2_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_neg_r[i] <= s1_d_r[i][DIFF_W-1];
      s2_mag_r[i] <= s1_d_r[i][DIFF_W-1] ? DIFF_W'(-s1_d_r[i]) : DIFF_W'(s1_d_r[i]);
    end
    s2_rr_r <= s1_rsum_r * s1_rsum_r;
  end

  // ---------------- s3: squares
  logic            s3_vld_r;
  logic [SQ_W-1:0] s3_sq_r [3];
  logic [2:0]      s3_neg_r;
  logic [2:0][MAG_W-1:0] s3_mag_r;
  logic [RR_W-1:0] s3_rr_r;
  logic [2*DIFF_W-1:0] s3_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) s3_prod[i] = s2_mag_r[i] * s2_mag_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_sq_r[i]  <= s3_prod[i][SQ_W-1:0];
      s3_mag_r[i] <= s2_mag_r[i][MAG_W-1:0];
    end
    s3_neg_r <= s2_neg_r;
    s3_rr_r  <= s2_rr_r;
  end

  // ---------------- s4: squared length
  logic            s4_vld_r;
  logic [DD_W-1:0] s4_dd_r;
  logic [2:0]      s4_neg_r;
  logic [2:0][MAG_W-1:0] s4_mag_r;
  logic [RR_W-1:0] s4_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    s4_dd_r  <= DD_W'(s3_sq_r[0]) + DD_W'(s3_sq_r[1]) + DD_W'(s3_sq_r[2]);
    s4_neg_r <= s3_neg_r;
    s4_mag_r <= s3_mag_r;
    s4_rr_r  <= s3_rr_r;
  end

  // ---------------- s5 / root stage 0: compares, root setup
  logic  rt_vld_r  [SQRT_STEPS+1];
  side_t rt_side_r [SQRT_STEPS+1];
  logic [RR_W-1:0]   rt_src_r  [SQRT_STEPS+1];
  logic [REM_W-1:0]  rt_rem_r  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] rt_root_r [SQRT_STEPS+1];

  logic s5_touch, s5_norm;
  assign s5_touch = (s4_dd_r[DD_W-1:RR_W] == '0) && (s4_dd_r[RR_W-1:0] <= s4_rr_r);
  assign s5_norm  = s5_touch && (s4_dd_r[RR_W-1:0] > RR_W'(sep_sq));

  always_ff @(posedge clk) begin
    if (!rst_n) rt_vld_r[0] <= 1'b0;
    else        rt_vld_r[0] <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    rt_side_r[0].touch   <= s5_touch;
    rt_side_r[0].norm_en <= s5_norm;
    rt_side_r[0].neg     <= s4_neg_r;
    rt_side_r[0].mag     <= s4_mag_r;
    rt_src_r[0]          <= s4_dd_r[RR_W-1:0];
    rt_rem_r[0]          <= '0;
    rt_root_r[0]         <= '0;
  end

  // one root bit per stage, two radicand bits consumed
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    logic [REM_W-1:0] rem_sh, trial;
    logic             take;

    assign rem_sh = {rt_rem_r[k][REM_W-3:0], rt_src_r[k][RR_W-1:RR_W-2]};
    assign trial  = {rt_root_r[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) rt_vld_r[k+1] <= 1'b0;
      else        rt_vld_r[k+1] <= rt_vld_r[k];
    end

    always_ff @(posedge clk) begin
      rt_side_r[k+1] <= rt_side_r[k];
      rt_src_r[k+1]  <= {rt_src_r[k][RR_W-3:0], 2'b00};
      rt_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
      rt_root_r[k+1] <= {rt_root_r[k][ROOT_W-2:0], take};
    end
  end

  // ---------------- divider setup: rounded numerators
  logic  dv_vld_r  [DIV_STEPS+1];
  side_t dv_side_r [DIV_STEPS+1];
  logic [ROOT_W-1:0] dv_den_r [DIV_STEPS+1];
  logic [2:0][ROOT_W-1:0] dv_rem_r [DIV_STEPS+1];
  logic [2:0][QUO_W-1:0]  dv_low_r [DIV_STEPS+1];
  logic [2:0][QUO_W-1:0]  dv_quo_r [DIV_STEPS+1];

  logic [NUM_W-1:0] dp_num [3];
  logic [ROOT_W-1:0] dp_s;
  assign dp_s = rt_root_r[SQRT_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_num[i] = {1'b0, rt_side_r[SQRT_STEPS].mag[i], 30'b0} + NUM_W'(dp_s >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= rt_vld_r[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    dv_side_r[0] <= rt_side_r[SQRT_STEPS];
    dv_den_r[0]  <= dp_s;
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= dp_num[i][NUM_W-1:QUO_W];
      dv_low_r[0][i] <= dp_num[i][QUO_W-1:0];
      dv_quo_r[0][i] <= '0;
    end
  end

  // one quotient bit per stage on all three lanes, shared divisor
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [ROOT_W:0] part [3];
    logic [2:0]      take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {dv_rem_r[k][i], dv_low_r[k][i][QUO_W-1]};
        take[i] = part[i] >= {1'b0, dv_den_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else        dv_vld_r[k+1] <= dv_vld_r[k];
    end

    always_ff @(posedge clk) begin
      dv_side_r[k+1] <= dv_side_r[k];
      dv_den_r[k+1]  <= dv_den_r[k];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[k+1][i] <= take[i] ? ROOT_W'(part[i] - {1'b0, dv_den_r[k]})
                                    : ROOT_W'(part[i]);
        dv_low_r[k+1][i] <= {dv_low_r[k][i][QUO_W-2:0], 1'b0};
        dv_quo_r[k+1][i] <= {dv_quo_r[k][i][QUO_W-2:0], take[i]};
      end
    end
  end

  // ---------------- output register
  side_t fin_side;
  logic [NORM_W-1:0] fin_n [3];
  logic [NORM_W-1:0] q_ext;

  assign fin_side = dv_side_r[DIV_STEPS];

  always_comb begin
    q_ext = '0;
    for (int i = 0; i < 3; i++) begin
      q_ext = {1'b0, dv_quo_r[DIV_STEPS][i]};
      if (!fin_side.touch)        fin_n[i] = '0;
      else if (!fin_side.norm_en) fin_n[i] = (i == 1) ? NORMAL_ONE : '0;
      else if (fin_side.neg[i])   fin_n[i] = -q_ext;
      else                        fin_n[i] = q_ext;
    end
  end

  logic                      out_vld_r, out_touch_r;
  logic signed [COORD_W-1:0] out_cx_r, out_cy_r, out_cz_r;
  logic signed [NORM_W-1:0]  out_nx_r, out_ny_r, out_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    out_touch_r <= fin_side.touch;
    out_cx_r    <= fin_side.touch ? ctr_x_r : '0;
    out_cy_r    <= fin_side.touch ? ctr_y_r : '0;
    out_cz_r    <= fin_side.touch ? ctr_z_r : '0;
    out_nx_r    <= fin_n[0];
    out_ny_r    <= fin_n[1];
    out_nz_r    <= fin_n[2];
  end

  assign out_valid     = out_vld_r;
  assign out_touching  = out_touch_r;
  assign out_contact_x = out_cx_r;
  assign out_contact_y = out_cy_r;
  assign out_contact_z = out_cz_r;
  assign out_normal_x  = out_nx_r;
  assign out_normal_y  = out_ny_r;
  assign out_normal_z  = out_nz_r;

  // ---------------- checks
  `SSC_ASSERT_IMP(a_fixed_latency, start && !busy, ##LATENCY out_valid)
  `SSC_ASSERT_IMP(a_miss_zero, out_valid && !out_touching, (out_normal_x == 0) && (out_normal_y == 0) && (out_normal_z == 0) && (out_contact_x == 0))
  `SSC_ASSERT_IMP(a_hit_normal, out_valid && out_touching, (out_normal_x != 0) || (out_normal_y != 0) || (out_normal_z != 0))

endmodule

/* tb/testbench.sv */
module testbench
  import ssc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              touching;
    logic [31:0]       cx, cy, cz;
    logic [31:0]       nx, ny, nz;
  } contact_t;

  class contact_scoreboard;
    logic signed [31:0] center_x, center_y, center_z;
    logic [30:0]        own_radius;
    logic [15:0]        min_sep;
    contact_t           pending[$];
    int                 errors;
    int                 checked;
    int                 touches;

    function new();
      center_x = '0; center_y = '0; center_z = '0;
      own_radius = '0; min_sep = 16'd1;
      errors = 0; checked = 0; touches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_CENTER_X:   center_x = data;
        REG_CENTER_Y:   center_y = data;
        REG_CENTER_Z:   center_z = data;
        REG_OWN_RADIUS: own_radius = data[30:0];
        REG_MIN_SEP:    min_sep = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [31:0] unit_comp(longint d, logic [63:0] s);
      logic [63:0] m;
      logic [63:0] q;
      m = (d < 0) ? -d : d;
      q = (m * 64'h4000_0000 + (s >> 1)) / s;
      if (d < 0) q = -q;
      return q[31:0];
    endfunction

    // probe accepted: work out its contact word
    function void note_probe(logic signed [31:0] px, py, pz, logic [30:0] pr);
      longint      dx, dy, dz;
      logic [66:0] mx, my, mz, dd;
      logic [63:0] rsum, rr, sep_sq, s;
      contact_t    e;
      dx = longint'(px) - longint'(center_x);
      dy = longint'(py) - longint'(center_y);
      dz = longint'(pz) - longint'(center_z);
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      mz = (dz < 0) ? -dz : dz;
      dd = mx * mx + my * my + mz * mz;
      rsum = 64'(own_radius) + 64'(pr);
      rr = rsum * rsum;
      sep_sq = 64'(min_sep) * 64'(min_sep);
      e = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      if (dd <= {3'b000, rr}) begin
        e.touching = 1'b1;
        e.cx = center_x; e.cy = center_y; e.cz = center_z;
        if (dd[63:0] > sep_sq) begin
          s = int_sqrt(dd[63:0]);
          e.nx = unit_comp(dx, s);
          e.ny = unit_comp(dy, s);
          e.nz = unit_comp(dz, s);
        end else begin
          e.ny = NORMAL_ONE;
        end
      end
      pending.push_back(e);
    endfunction

    function void mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, act_v);
    endfunction

    function void check_result(contact_t a);
      contact_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t unexpected result word", $realtime);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.touching) touches++;
      if (a.touching !== e.touching) mismatch("touching", e.touching, a.touching);
      if (a.cx !== e.cx) mismatch("contact_x", e.cx, a.cx);
      if (a.cy !== e.cy) mismatch("contact_y", e.cy, a.cy);
      if (a.cz !== e.cz) mismatch("contact_z", e.cz, a.cz);
      if (a.nx !== e.nx) mismatch("normal_x", e.nx, a.nx);
      if (a.ny !== e.ny) mismatch("normal_y", e.ny, a.ny);
      if (a.nz !== e.nz) mismatch("normal_z", e.nz, a.nz);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_probe_x = '0, in_probe_y = '0, in_probe_z = '0;
  logic [RAD_W-1:0] in_probe_radius = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid, out_touching;
  logic signed [COORD_W-1:0] out_contact_x, out_contact_y, out_contact_z;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;

  contact_scoreboard sb = new();
  bit no_gaps = 0;

  always #4 clk = ~clk;

  sphere_sphere_contact_core u_dut (
    .clk, .rst_n, .start, .busy,
    .in_probe_x, .in_probe_y, .in_probe_z, .in_probe_radius,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_touching,
    .out_contact_x, .out_contact_y, .out_contact_z,
    .out_normal_x, .out_normal_y, .out_normal_z
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_probe(in_probe_x, in_probe_y, in_probe_z, in_probe_radius);
      if (out_valid)
        sb.check_result('{out_touching, out_contact_x, out_contact_y, out_contact_z,
                          out_normal_x, out_normal_y, out_normal_z});
    end
  end

  task automatic send_probe(logic [31:0] px, py, pz, logic [30:0] pr);
    if (!no_gaps && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_probe_x <= px;
    in_probe_y <= py;
    in_probe_z <= pz;
    in_probe_radius <= pr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // cfg_valid drops after each word, which keeps back to back writes apart
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sphere(logic [31:0] cx, cy, cz, r, sep);
    write_cfg(REG_CENTER_X, cx);
    write_cfg(REG_CENTER_Y, cy);
    write_cfg(REG_CENTER_Z, cz);
    write_cfg(REG_OWN_RADIUS, r);
    write_cfg(REG_MIN_SEP, sep);
  endtask

  function automatic logic [31:0] offset(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // mostly probes near the fixed sphere, some across the full range
  task automatic random_probe();
    int          mode;
    int          span;
    logic [31:0] rad;
    mode = $urandom_range(9);
    span = 1 << $urandom_range(24, 2);
    rad = $urandom & ((32'd1 << $urandom_range(31, 1)) - 1);
    case (mode)
      0, 1:
        send_probe($urandom, $urandom, $urandom, 31'($urandom));
      2:
        send_probe(sb.center_x + offset(8), sb.center_y + offset(8),
                   sb.center_z + offset(8), 31'($urandom_range(16)));
      default:
        send_probe(sb.center_x + offset(span), sb.center_y + offset(span),
                   sb.center_z + offset(span), 31'(rad[30:0] % (3 * span)));
    endcase
  endtask

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: coincident, boundary, just outside, extremes
    send_probe(0, 0, 0, 0);
    send_probe(0, 0, 0, 31'h7FFF_FFFF);
    send_probe(32'h0001_0000, 0, 0, 31'h0001_0000);
    send_probe(32'h0001_0001, 0, 0, 31'h0001_0000);
    send_probe(0, 32'hFFFF_0000, 0, 31'h0001_0000);
    send_probe(0, 0, 32'h8000_0000, 31'h7FFF_FFFF);
    send_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_probe(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_probe(1, 0, 0, 0);
    send_probe(1, 1, 0, 2);
    send_probe(32'hFFFF_FFFD, 4, 0, 5);
    drain();

    // far corner center: offsets reach 2^32-1 per axis, so dd exceeds 2^64
    set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_cfg(3'd5, 32'h1234_5678);
    write_cfg(3'd7, 32'hFFFF_FFFF);
    send_probe(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_probe(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_probe(32'h8000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_probe(32'h8001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_probe(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_sphere(0, 0, 0, 0, 0);
        1: set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        2: set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
        default:
          set_sphere($urandom, $urandom, $urandom,
                     $urandom & ((32'd1 << $urandom_range(31, 1)) - 1),
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(64));
      endcase
      no_gaps = (ph == 7);
      for (int i = 0; i < 200; i++) random_probe();
      drain();
    end

    $display("checked %0d contact words (%0d touching) over 10 sphere settings",
             sb.checked, sb.touches);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d words outstanding", sb.errors, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssc_pkg.sv
rtl/sphere_sphere_contact_core.sv
tb/testbench.sv
